[rtl/ndd_pkg.sv]
package ndd_pkg;

  localparam int VALUE_W = 32;
  localparam int NDIG    = 10;
  localparam int CONV_W  = 5;

  localparam logic [CONV_W-1:0] CONV_LAST  = CONV_W'(VALUE_W - 1);
  localparam logic [7:0]        MINUS_CODE = 8'hFE;
  localparam logic [7:0]        SIGN_MARK  = 8'h80;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_DECIMAL_MODE  = 3'd0,
    REG_BLANK_LEADING = 3'd1,
    REG_MIN_DIGITS    = 3'd2,
    REG_DOT_DIGIT     = 3'd3,
    REG_BLANK_LIMIT   = 3'd4,
    REG_BLANK_CODE    = 3'd5,
    REG_PERIOD_CODE   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic               decimal_mode;
    logic               blank_leading;
    logic [4:0]         min_digits;
    logic signed [4:0]  dot_digit;
    logic signed [31:0] blank_limit;
    logic [7:0]         blank_code;
    logic [7:0]         period_code;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_PREP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic prep;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic conv_last;
    logic pos_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/ndd_regs.sv]
module ndd_regs
  import ndd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decimal_mode  <= 1'b1;
      cfg.blank_leading <= 1'b1;
      cfg.min_digits    <= 5'd1;
      cfg.dot_digit     <= -5'sd1;
      cfg.blank_limit   <= 32'sh7FFF_FFFF;
      cfg.blank_code    <= 8'd15;
      cfg.period_code   <= 8'd128;
    end else if (wr_en) begin
      case (idx)
        REG_DECIMAL_MODE:  cfg.decimal_mode  <= pwdata[0];
        REG_BLANK_LEADING: cfg.blank_leading <= pwdata[0];
        REG_MIN_DIGITS:    cfg.min_digits    <= pwdata[4:0];
        REG_DOT_DIGIT:     cfg.dot_digit     <= $signed(pwdata[4:0]);
        REG_BLANK_LIMIT:   cfg.blank_limit   <= $signed(pwdata);
        REG_BLANK_CODE:    cfg.blank_code    <= pwdata[7:0];
        REG_PERIOD_CODE:   cfg.period_code   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_DECIMAL_MODE:  prdata = {31'd0, cfg.decimal_mode};
      REG_BLANK_LEADING: prdata = {31'd0, cfg.blank_leading};
      REG_MIN_DIGITS:    prdata = {27'd0, cfg.min_digits};
      REG_DOT_DIGIT:     prdata = {{27{cfg.dot_digit[4]}}, cfg.dot_digit};
      REG_BLANK_LIMIT:   prdata = cfg.blank_limit;
      REG_BLANK_CODE:    prdata = {24'd0, cfg.blank_code};
      REG_PERIOD_CODE:   prdata = {24'd0, cfg.period_code};
      default:           prdata = '0;
    endcase
  end

endmodule

[rtl/ndd_ctrl.sv]
module ndd_ctrl
  import ndd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_CONVERT;
      ST_CONVERT: if (sts.conv_last) state_next = ST_PREP;
      ST_PREP:    state_next = ST_EMIT;
      ST_EMIT:    if (sts.out_free && sts.pos_last) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONVERT: cmd.step = 1'b1;
      ST_PREP:    cmd.prep = 1'b1;
      ST_EMIT:    cmd.emit = sts.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/ndd_datapath.sv]
module ndd_datapath
  import ndd_pkg::*;
#(
  parameter int POSITIONS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic signed [31:0] value,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         code_byte,
  output logic [3:0]         position,
  output logic               ok,
  output logic               last
);

  localparam logic [3:0] LAST_POS = 4'(POSITIONS - 1);
  localparam logic [4:0] TOP_POW  = 5'(POSITIONS - 1);
  localparam int         BIN_BITS = 8 * POSITIONS;

  // operand and conversion registers
  logic [31:0]          mag;
  logic [31:0]          bin;
  logic [NDIG-1:0][3:0] bcd;
  logic [CONV_W-1:0]    count;
  logic                 neg;
  logic                 blank;
  logic                 reject;
  logic [3:0]           ndig;
  logic [3:0]           shift;
  logic                 dropped;
  logic [3:0]           pos;
  logic                 lead;

  logic [31:0]          mag_c;
  logic                 reject_c;
  logic [NDIG-1:0][3:0] adj;
  logic [3:0]           ndig_c;
  logic [3:0]           shift_c;
  logic                 dropped_c;
  logic [4:0]           pow;
  logic [3:0]           digit;
  logic                 dot;
  logic                 in_lead_zone;
  logic                 blank_pos;
  logic [7:0]           bin_byte;
  logic [7:0]           code_c;
  logic                 ok_c;

  assign mag_c    = value[31] ? (~value + 32'd1) : value;
  assign reject_c = (BIN_BITS < VALUE_W) ? ((mag_c >> BIN_BITS) != '0) : 1'b0;

  // shift-add-3 step
  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      adj[k] = (bcd[k] >= 4'd5) ? bcd[k] + 4'd3 : bcd[k];
    end
  end

  // digit count and truncation mark
  always_comb begin
    ndig_c    = '0;
    dropped_c = 1'b0;
    for (int k = 0; k < NDIG; k++) begin
      if (bcd[k] != 4'd0) ndig_c = 4'(k + 1);
    end
    shift_c = ({1'b0, ndig_c} > 5'(POSITIONS)) ? 4'({1'b0, ndig_c} - 5'(POSITIONS)) : 4'd0;
    for (int k = 0; k < NDIG; k++) begin
      if (4'(k) < shift_c && bcd[k] != 4'd0) dropped_c = 1'b1;
    end
  end

  // per position formatting
  always_comb begin
    pow   = TOP_POW - {1'b0, pos} + {1'b0, shift};
    digit = (pow < 5'(NDIG)) ? bcd[pow[3:0]] : 4'd0;
    dot   = (!cfg.dot_digit[4] && pow == cfg.dot_digit && pow < {1'b0, ndig})
            || (pos == LAST_POS && dropped);
    in_lead_zone = ({2'b00, pos} + {1'b0, cfg.min_digits}) < 6'(POSITIONS);
    blank_pos = cfg.blank_leading && lead && in_lead_zone && digit == 4'd0 && !dot;
    bin_byte  = (pos < 4'd4) ? mag[{pos[1:0], 3'b000} +: 8] : 8'd0;
    ok_c      = 1'b1;
    if (blank) begin
      code_c = cfg.blank_code;
    end else if (cfg.decimal_mode) begin
      if (pos == 4'd0 && neg) begin
        code_c = MINUS_CODE;
      end else if (blank_pos) begin
        code_c = cfg.blank_code;
      end else begin
        code_c = {4'd0, digit} + (dot ? cfg.period_code : 8'd0);
      end
    end else if (reject) begin
      code_c = 8'd0;
      ok_c   = 1'b0;
    end else begin
      code_c = bin_byte | ((neg && pos == LAST_POS) ? SIGN_MARK : 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag    <= mag_c;
      bin    <= mag_c;
      bcd    <= '0;
      neg    <= value[31];
      blank  <= value > cfg.blank_limit;
      reject <= reject_c;
    end else if (cmd.step) begin
      bcd <= {adj[NDIG-1][2:0], adj[NDIG-2:0], bin[31]};
      bin <= {bin[30:0], 1'b0};
    end
    if (cmd.prep) begin
      ndig    <= ndig_c;
      shift   <= shift_c;
      dropped <= dropped_c;
    end
    if (cmd.emit) begin
      code_byte <= code_c;
      position  <= pos;
      ok        <= ok_c;
      last      <= pos == LAST_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pos       <= '0;
      lead      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        count <= '0;
      end else if (cmd.step) begin
        count <= count + CONV_W'(1);
      end
      if (cmd.prep) begin
        pos  <= '0;
        lead <= 1'b1;
      end else if (cmd.emit) begin
        pos  <= pos + 4'd1;
        lead <= blank_pos;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.conv_last = count == CONV_LAST;
  assign sts.pos_last  = pos == LAST_POS;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

[rtl/number_to_display_digits_unit.sv]
// Number to display digits formatter.
// Input channel: in_valid / in_ready with a signed 32-bit value. One transfer
// produces POSITIONS result transfers on out_valid / out_ready, position 0
// first, the final one marked by last. Each result carries code_byte, its
// position and ok (low only when binary mode rejects an oversized magnitude).
// Registers are written over the APB-style port at byte address 4*index;
// pready is always high and writes are meant to happen while the block idles.
// Sequence: after an input transfer a shift-add-3 unit runs one step per bit of
// the magnitude, a prep state then sizes the digit string, and the output
// stage emits one position per cycle while the receiver takes the results.
// in_ready returns in the cycle after the last result is loaded, so the
// next input can be taken while that result still waits.
// A stalled receiver holds the output register and pauses the position walk.
// Synchronous reset returns registers to their defaults, the controller to
// idle and drops any pending result.
module number_to_display_digits_unit
  import ndd_pkg::*;
#(
  parameter int POSITIONS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         code_byte,
  output logic [3:0]         position,
  output logic               ok,
  output logic               last
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  ndd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ndd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ndd_datapath #(
    .POSITIONS (POSITIONS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .code_byte (code_byte),
    .position  (position),
    .ok        (ok),
    .last      (last)
  );

endmodule

[rtl/ndd_checker.sv]
module ndd_checker #(
  parameter int POSITIONS = 8
) (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] code_byte,
  input logic [3:0] position,
  input logic       ok,
  input logic       last
);

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_byte) && $stable(position)
      && $stable(ok) && $stable(last))
    else $error("stalled result changed");

  // one value in flight
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // final transfer sits on the last position
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (last == (position == 4'(POSITIONS - 1))) || !out_valid)
    else $error("last flag and position disagree");

  // a rejected magnitude shows zero bytes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> code_byte == 8'd0)
    else $error("rejected result with nonzero code");

endmodule

bind number_to_display_digits_unit ndd_checker #(
  .POSITIONS (POSITIONS)
) u_ndd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .code_byte (code_byte),
  .position  (position),
  .ok        (ok),
  .last      (last)
);

[tb/tb_number_to_display_digits_unit.sv]
`timescale 1ns / 1ps

module tb_number_to_display_digits_unit;
  import ndd_pkg::*;

  localparam int NPOS = 8;

  typedef struct packed {
    logic [7:0] code;
    logic [3:0] pos;
    logic       ok;
    logic       last;
  } pos_code_t;

  // expected display codes, worked out from a mirror of the register file
  class display_code_book;
    bit              decimal_mode;
    bit              blank_leading;
    bit [4:0]        min_digits;
    int              dot_digit;
    int              blank_limit;
    bit [7:0]        blank_code;
    bit [7:0]        period_code;
    pos_code_t       due_codes[$];
    int              errors;

    function new();
      decimal_mode  = 1'b1;
      blank_leading = 1'b1;
      min_digits    = 5'd1;
      dot_digit     = -1;
      blank_limit   = 2147483647;
      blank_code    = 8'd15;
      period_code   = 8'd128;
      errors        = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] d);
      case (idx)
        REG_DECIMAL_MODE:  decimal_mode  = d[0];
        REG_BLANK_LEADING: blank_leading = d[0];
        REG_MIN_DIGITS:    min_digits    = d[4:0];
        REG_DOT_DIGIT:     dot_digit     = int'($signed(d[4:0]));
        REG_BLANK_LIMIT:   blank_limit   = $signed(d);
        REG_BLANK_CODE:    blank_code    = d[7:0];
        REG_PERIOD_CODE:   period_code   = d[7:0];
        default: ;
      endcase
    endfunction

    function void note_value(logic signed [31:0] v);
      longint          sval;
      bit              neg;
      bit [31:0]       mag;
      bit [31:0]       m;
      longint unsigned wide;
      bit [7:0]        codes[NPOS];
      bit [3:0]        digit[NPOS];
      bit              dot[NPOS];
      bit [3:0]        dig[10];
      int              ndig;
      int              idx;
      int              p;
      int              lim;
      bit              dropped;
      bit              ok_bit;
      pos_code_t       r;
      sval   = v;
      neg    = sval < 0;
      mag    = neg ? 32'(-sval) : 32'(sval);
      ok_bit = 1'b1;
      if (sval > longint'(blank_limit)) begin
        foreach (codes[i]) codes[i] = blank_code;
      end else if (decimal_mode) begin
        foreach (digit[i]) begin
          digit[i] = 4'd0;
          dot[i]   = 1'b0;
        end
        m    = mag;
        ndig = 0;
        while (m != 0 && ndig < 10) begin
          dig[ndig] = 4'(m % 10);
          m = m / 10;
          ndig++;
        end
        if (ndig > 0) begin
          // keep the high digits, mark the last position if anything nonzero fell off
          idx     = (NPOS > ndig) ? NPOS - ndig : 0;
          p       = ndig - 1;
          dropped = 1'b0;
          while (p >= 0 && idx < NPOS) begin
            digit[idx] = dig[p];
            if (p == dot_digit) dot[idx] = 1'b1;
            p--;
            idx++;
          end
          while (p >= 0) begin
            if (dig[p] != 0) dropped = 1'b1;
            p--;
          end
          if (dropped) dot[NPOS-1] = 1'b1;
        end
        foreach (codes[i]) codes[i] = 8'({4'd0, digit[i]} + (dot[i] ? period_code : 8'd0));
        if (blank_leading) begin
          lim = NPOS - int'(min_digits);
          for (int i = 0; i < lim; i++) begin
            if (digit[i] == 0 && !dot[i]) codes[i] = blank_code;
            else break;
          end
        end
        if (neg) codes[0] = MINUS_CODE;
      end else begin
        wide = mag;
        if (8 * NPOS < 64 && wide >= (64'd1 << (8 * NPOS))) begin
          ok_bit = 1'b0;
          foreach (codes[i]) codes[i] = 8'd0;
        end else begin
          foreach (codes[i]) codes[i] = 8'(wide >> (8 * i));
          if (neg) codes[NPOS-1] = codes[NPOS-1] | SIGN_MARK;
        end
      end
      for (int i = 0; i < NPOS; i++) begin
        r.code = codes[i];
        r.pos  = 4'(i);
        r.ok   = ok_bit;
        r.last = (i == NPOS - 1);
        due_codes.push_back(r);
      end
    endfunction

    function void check_code(logic [7:0] code, logic [3:0] pos, logic okv, logic lastv);
      pos_code_t e;
      if (due_codes.size() == 0) begin
        $error("code_byte transfer with nothing expected: code_byte %0h position %0d",
               code, pos);
        errors++;
        return;
      end
      e = due_codes.pop_front();
      if (code !== e.code) begin
        $error("code_byte mismatch: expected %0h, actual %0h", e.code, code);
        errors++;
      end
      if (pos !== e.pos) begin
        $error("position mismatch: expected %0d, actual %0d", e.pos, pos);
        errors++;
      end
      if (okv !== e.ok) begin
        $error("ok mismatch: expected %0b, actual %0b", e.ok, okv);
        errors++;
      end
      if (lastv !== e.last) begin
        $error("last mismatch: expected %0b, actual %0b", e.last, lastv);
        errors++;
      end
    endfunction

    function int pending();
      return due_codes.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         code_byte;
  logic [3:0]         position;
  logic               ok;
  logic               last;

  display_code_book book = new();
  bit calm = 1'b0;
  int stall_left = 0;

  number_to_display_digits_unit #(
    .POSITIONS(NPOS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_byte (code_byte),
    .position  (position),
    .ok        (ok),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver stalls in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) book.note_value(value);
      if (out_valid && out_ready) book.check_code(code_byte, position, ok, last);
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    book.set_reg(idx, d);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input bit dm, input bit bl, input int md, input int dd,
                               input int lim, input int bc, input int pc);
    apb_write(REG_DECIMAL_MODE, 32'(dm));
    apb_write(REG_BLANK_LEADING, 32'(bl));
    apb_write(REG_MIN_DIGITS, 32'(md));
    apb_write(REG_DOT_DIGIT, 32'(dd));
    apb_write(REG_BLANK_LIMIT, 32'(lim));
    apb_write(REG_BLANK_CODE, 32'(bc));
    apb_write(REG_PERIOD_CODE, 32'(pc));
  endtask

  task automatic send_value(input logic signed [31:0] v);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait until every code of the phase has come back and the block idles
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    int              kind;
    int              nd;
    bit              neg;
    longint unsigned span;
    longint unsigned m;
    longint          s;
    kind = $urandom_range(0, 9);
    case (kind)
      0: return $signed($urandom());
      1: begin
        case ($urandom_range(0, 5))
          0: return 32'sd0;
          1: return 32'sd1;
          2: return -32'sd1;
          3: return 32'sh7fffffff;
          4: return 32'sh80000000;
          default: return -32'sh7fffffff;
        endcase
      end
      2: return 32'(book.blank_limit + $urandom_range(0, 2) - 1);
      default: begin
        // magnitude with a chosen digit count so short and truncated strings both occur
        nd   = $urandom_range(1, 10);
        span = 1;
        repeat (nd) span = span * 10;
        if (span > 64'd2147483649) span = 64'd2147483649;
        m   = {$urandom(), $urandom()} % span;
        neg = $urandom_range(0, 1);
        if (m == 64'd2147483648) neg = 1'b1;
        s = neg ? -longint'(m) : longint'(m);
        return 32'(s);
      end
    endcase
  endfunction

  initial begin
    bit dm;
    int lim;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    value    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: zero, sign extremes, truncation with and without a lost digit
    send_value(32'sd0);
    send_value(32'sd1);
    send_value(-32'sd1);
    send_value(-32'sd5);
    send_value(32'sd99999999);
    send_value(32'sd100000000);
    send_value(32'sd123456789);
    send_value(32'sh7fffffff);
    send_value(-32'sh7fffffff);
    send_value(32'sh80000000);
    send_value(-32'sd12345);
    settle();

    // period at a digit, a blanking limit and a doubled period on the last position
    apply_setting(1'b1, 1'b1, 3, 2, 1000, 8'h00, 8'hff);
    send_value(32'sd0);
    send_value(32'sd5);
    send_value(32'sd1000);
    send_value(32'sd1001);
    send_value(-32'sd999999999);
    send_value(-32'sd1234567891);
    settle();

    apply_setting(1'b0, 1'b1, 1, -1, 2147483647, 8'd15, 8'd128);
    send_value(32'sd0);
    send_value(-32'sd1);
    send_value(32'sh7fffffff);
    send_value(32'sh80000000);
    send_value(32'sh12345678);
    settle();

    apply_setting(1'b1, 1'b0, 16, 15, -2147483647, 8'hff, 8'h80);
    send_value(32'sh80000000);
    send_value(-32'sh7fffffff);
    send_value(32'sd0);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 9) || ($urandom_range(0, 3) == 0);
      dm   = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
        0: lim = $signed($urandom());
        1: lim = $urandom_range(0, 2000) - 1000;
        default: lim = 2147483647;
      endcase
      if (lim == -2147483648) lim = 2147483647;
      apply_setting(dm, $urandom_range(0, 1),
                    (ph == 0) ? 0 : $urandom_range(0, 16),
                    $urandom_range(0, 16) - 1, lim,
                    (ph == 1) ? 255 : $urandom_range(0, 255),
                    (ph == 1) ? 0 : $urandom_range(0, 255));
      repeat (45) send_value(pick_value());
      settle();
    end

    repeat (50) @(posedge clk);
    if (book.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
